// File: design/mnbs_pkg.sv
// Package for the mixed number bubble sorter: payload structs, sizes and
// sequencer state encoding. No dependencies.
package mnbs_pkg;

    localparam int CAPACITY = 32;
    localparam int MAX_EMIT = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic signed [15:0] whole_part;
        logic [15:0]        numerator;
        logic [15:0]        denominator;
        logic               is_last;
    } t_in;

    typedef struct packed {
        logic signed [15:0] out_whole;
        logic [15:0]        out_numerator;
        logic [15:0]        out_denominator;
        logic               out_last;
        logic               overflowed;
    } t_out;

    // one stored element: whole, numerator, denominator
    typedef struct packed {
        logic signed [15:0] whole;
        logic [15:0]        num;
        logic [15:0]        den;
    } t_elem;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PASS,
        S_HMUL,
        S_HADD,
        S_READ,
        S_TMUL,
        S_TADD,
        S_LHS,
        S_RHS,
        S_CMP,
        S_WEND,
        S_ERD,
        S_ELD,
        S_EOUT
    } t_state;

endpackage

// File: design/mixed_number_bubble_sorter.sv
// Mixed number bubble sorter: loads, sorts and emits a list of mixed numbers.
// Depends on mnbs_pkg.
//
// Items are loaded one per cycle into a 32-entry store; the item flagged
// is_last starts a stable ascending sort, after which the list leaves in
// order with out_last on its final element. Items arriving with the store
// full are dropped and flagged through overflowed on every result of that
// run. Values are compared exactly by cross-multiplying through a single
// shared 32x17 signed multiplier and a one-read, one-write store. Each pass
// carries the larger element forward, and the input is not ready during
// sorting and emission. Each result is read from the store, loaded into the
// output register and then held on the output until it is taken.
module mixed_number_bubble_sorter
    import mnbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_state r_state, n_state;

    t_elem             mem [CAPACITY];
    t_elem             r_rd_data;
    t_elem             r_held;
    t_elem             r_nxt;
    logic signed [31:0] r_ta, r_tb;
    logic signed [48:0] r_prod, r_lhs;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [IDX_W-1:0]  r_k, r_e, r_j;
    t_out              r_out;

    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    t_elem             wr_data;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    logic              in_fire, gt, full, emit_last;
    logic [CNT_W-1:0]  emit_n;

    assign in_fire = i_in_valid && o_in_ready;
    assign full    = (r_count >= CNT_W'(CAPACITY));
    assign gt      = (r_lhs > r_prod);
    assign mul_p   = mul_a * mul_b;
    assign emit_n  = (r_count > CNT_W'(MAX_EMIT)) ? CNT_W'(MAX_EMIT) : r_count;
    assign emit_last = ({1'b0, r_j} == (emit_n - CNT_W'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire && i_in_data.is_last) n_state = S_START;
            S_START: n_state = (r_count == CNT_W'(1)) ? S_ERD : S_PASS;
            S_PASS:  n_state = S_HMUL;
            S_HMUL:  n_state = S_HADD;
            S_HADD:  n_state = S_READ;
            S_READ:  n_state = S_TMUL;
            S_TMUL:  n_state = S_TADD;
            S_TADD:  n_state = S_LHS;
            S_LHS:   n_state = S_RHS;
            S_RHS:   n_state = S_CMP;
            S_CMP:   n_state = (r_k + IDX_W'(1) == r_e) ? S_WEND : S_READ;
            S_WEND:  n_state = (r_e == IDX_W'(1)) ? S_ERD : S_PASS;
            S_ERD:   n_state = S_ELD;
            S_ELD:   n_state = S_EOUT;
            S_EOUT: begin
                if (i_out_ready) n_state = r_out.out_last ? S_IDLE : S_ERD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = r_held;
        mul_a       = '0;
        mul_b       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                wr_en      = in_fire && !full;
                wr_addr    = r_count[IDX_W-1:0];
                wr_data    = '{whole: i_in_data.whole_part, num: i_in_data.numerator,
                               den: i_in_data.denominator};
            end
            S_PASS: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_HMUL, S_TMUL: begin
                mul_a = 32'(r_rd_data.whole);
                mul_b = {1'b0, r_rd_data.den};
            end
            S_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_k + IDX_W'(1);
            end
            S_LHS: begin
                mul_a = r_ta;
                mul_b = {1'b0, r_nxt.den};
            end
            S_RHS: begin
                mul_a = r_tb;
                mul_b = {1'b0, r_held.den};
            end
            S_CMP: begin
                // smaller of the pair drops back, larger carries on
                wr_en   = 1'b1;
                wr_addr = r_k;
                wr_data = gt ? r_nxt : r_held;
            end
            S_WEND: begin
                wr_en   = 1'b1;
                wr_addr = r_e;
                wr_data = r_held;
            end
            S_ERD: begin
                rd_en   = 1'b1;
                rd_addr = r_j;
            end
            S_EOUT:  o_out_valid = 1'b1;
            default: ;
        endcase
    end

    // element store
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_HMUL: begin
                r_held <= r_rd_data;
                r_prod <= mul_p;
            end
            S_HADD: r_ta <= r_prod[31:0] + 32'(r_held.num);
            S_TMUL: begin
                r_nxt  <= r_rd_data;
                r_prod <= mul_p;
            end
            S_TADD: r_tb <= r_prod[31:0] + 32'(r_nxt.num);
            S_LHS:  r_lhs <= mul_p;
            S_RHS:  r_prod <= mul_p;
            S_CMP: begin
                if (!gt) begin
                    r_held <= r_nxt;
                    r_ta   <= r_tb;
                end
            end
            S_ELD: begin
                r_out.out_whole       <= r_rd_data.whole;
                r_out.out_numerator   <= r_rd_data.num;
                r_out.out_denominator <= r_rd_data.den;
                r_out.out_last        <= emit_last;
                r_out.overflowed      <= r_ovf;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
            r_e     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (full) r_ovf <= 1'b1;
                        else      r_count <= r_count + CNT_W'(1);
                    end
                end
                S_START: begin
                    r_e <= IDX_W'(r_count - CNT_W'(1));
                    r_k <= '0;
                    r_j <= '0;
                end
                S_CMP:  r_k <= r_k + IDX_W'(1);
                S_WEND: begin
                    r_e <= r_e - IDX_W'(1);
                    r_k <= '0;
                end
                S_EOUT: begin
                    if (i_out_ready) begin
                        if (r_out.out_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end else begin
                            r_j <= r_j + IDX_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_data = r_out;

endmodule
